// ----- rtl/core/tiled_rgb5a3_texture_decoder_unit_assert.svh -----
// ----------------------------------------------------------------------------
// tiled rgb5a3 texture decoder assertion macros
// concurrent assertion wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef TILED_RGB5A3_TEXTURE_DECODER_UNIT_ASSERT_SVH
`define TILED_RGB5A3_TEXTURE_DECODER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// checked on every clock edge outside reset
`define TRTD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("trtd assertion failed");

// checked on every clock edge, reset included
`define TRTD_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("trtd assertion failed");

`else

`define TRTD_ASSERT(lbl, prop)
`define TRTD_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// ----- rtl/core/trtd_pkg.sv -----
// ----------------------------------------------------------------------------
// trtd_pkg
// shared types, constants and color helpers of the tiled rgb5a3 decoder
// ----------------------------------------------------------------------------
`default_nettype none

package trtd_pkg;

    localparam int PALETTE_DEPTH    = 256;
    localparam int MAX_IMAGE_WIDTH  = 128;
    localparam int MAX_IMAGE_HEIGHT = 64;
    localparam int PAL_AW           = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic {
        OP_TEXEL         = 1'b0,
        OP_PALETTE_WRITE = 1'b1
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INDEXED_MODE = 2'd0,
        REG_IMAGE_WIDTH  = 2'd1,
        REG_IMAGE_HEIGHT = 2'd2,
        REG_BACKGROUND   = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        t_opcode     opcode;
        logic [15:0] texel_data;
        logic [7:0]  palette_index;
        logic [15:0] palette_word;
    } t_in_req;

    typedef struct packed {
        logic [6:0] pixel_x;
        logic [5:0] pixel_y;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_pixel;
    } t_out_res;

    typedef struct packed {
        logic [6:0] pixel_x;
        logic [5:0] pixel_y;
        logic       last_pixel;
    } t_pos;

    function automatic logic [7:0] widen5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [7:0] widen3(input logic [2:0] a3);
        return {a3, a3, a3[2:1]};
    endfunction

    // exact quotient by 255 for numerators up to 255*255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return t[15:8];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/trtd_position.sv -----
// ----------------------------------------------------------------------------
// trtd_position
// tile walk counters giving raster position and last pixel flag
// ----------------------------------------------------------------------------
`default_nettype none

module trtd_position (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_clear,
    input  wire logic          i_step,
    input  wire logic          i_indexed,
    input  wire logic [7:0]    i_image_width,
    input  wire logic [6:0]    i_image_height,
    output trtd_pkg::t_pos     o_pos
);
    import trtd_pkg::*;

    logic [6:0] r_col_base, n_col_base;
    logic [5:0] r_row_base, n_row_base;
    logic [1:0] r_row, n_row;
    logic [2:0] r_col, n_col;

    logic [7:0] w_clamp, w_eff;
    logic [6:0] h_clamp, h_eff;
    logic [3:0] tile_w;
    logic [3:0] col_inc;
    logic [7:0] col_base_inc;
    logic [6:0] row_base_inc;

    always_comb begin
        w_clamp = (i_image_width > 8'(MAX_IMAGE_WIDTH)) ? 8'(MAX_IMAGE_WIDTH) : i_image_width;
        w_eff   = {w_clamp[7:3], 3'b000};
        if (w_eff < 8'd8) begin
            w_eff = 8'd8;
        end
        h_clamp = (i_image_height > 7'(MAX_IMAGE_HEIGHT)) ? 7'(MAX_IMAGE_HEIGHT)
                                                          : i_image_height;
        h_eff   = {h_clamp[6:2], 2'b00};
        if (h_eff < 7'd4) begin
            h_eff = 7'd4;
        end
    end

    always_comb begin
        tile_w       = i_indexed ? 4'd8 : 4'd4;
        o_pos.pixel_x = r_col_base + {4'd0, r_col};
        o_pos.pixel_y = r_row_base + {4'd0, r_row};
        o_pos.last_pixel = ({1'b0, o_pos.pixel_x} == w_eff - 8'd1)
                        && ({1'b0, o_pos.pixel_y} == h_eff - 7'd1);

        col_inc      = {1'b0, r_col} + 4'd1;
        col_base_inc = {1'b0, r_col_base} + {4'd0, tile_w};
        row_base_inc = {1'b0, r_row_base} + 7'd4;

        n_col      = r_col;
        n_row      = r_row;
        n_col_base = r_col_base;
        n_row_base = r_row_base;
        if (i_clear) begin
            n_col      = '0;
            n_row      = '0;
            n_col_base = '0;
            n_row_base = '0;
        end else if (i_step) begin
            n_col = col_inc[2:0];
            if (col_inc >= tile_w) begin
                n_col = '0;
                n_row = r_row + 2'd1;
                if (r_row == 2'd3) begin
                    n_col_base = col_base_inc[6:0];
                    if (col_base_inc >= w_eff) begin
                        n_col_base = '0;
                        n_row_base = row_base_inc[5:0];
                        if (row_base_inc >= h_eff) begin
                            n_row_base = '0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_col_base <= '0;
            r_row_base <= '0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_col_base <= n_col_base;
            r_row_base <= n_row_base;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/trtd_palette.sv -----
// ----------------------------------------------------------------------------
// trtd_palette
// palette memory and first pipeline stage selecting the rgb5a3 word
// ----------------------------------------------------------------------------
`default_nettype none

module trtd_palette (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_accept,
    input  wire trtd_pkg::t_in_req i_req,
    input  wire trtd_pkg::t_pos    i_pos,
    input  wire logic              i_indexed,
    output logic                   o_valid,
    output logic [15:0]            o_word,
    output trtd_pkg::t_pos         o_pos
);
    import trtd_pkg::*;

    logic [15:0] mem [PALETTE_DEPTH];

    logic [15:0] r_rd_data;
    logic [15:0] r_texel;
    logic        r_in_range;
    logic        r_valid;
    t_pos        r_pos;

    logic        wr_en;

    assign wr_en = i_accept && (i_req.opcode == OP_PALETTE_WRITE)
                && (32'(i_req.palette_index) < PALETTE_DEPTH);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[i_req.palette_index[PAL_AW-1:0]] <= i_req.palette_word;
        end
        if (i_en) begin
            r_rd_data <= mem[i_req.texel_data[PAL_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_texel    <= i_req.texel_data;
            r_in_range <= 32'(i_req.texel_data[7:0]) < PALETTE_DEPTH;
            r_pos      <= i_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_accept && (i_req.opcode == OP_TEXEL);
        end
    end

    always_comb begin
        if (i_indexed) begin
            o_word = r_in_range ? r_rd_data : 16'd0;
        end else begin
            o_word = r_texel;
        end
    end

    assign o_valid = r_valid;
    assign o_pos   = r_pos;

endmodule

`default_nettype wire

// ----- rtl/core/trtd_color.sv -----
// ----------------------------------------------------------------------------
// trtd_color
// rgb5a3 expansion and background blend, two stages ending in the result
// ----------------------------------------------------------------------------
`default_nettype none

module trtd_color (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire logic [15:0]     i_word,
    input  wire trtd_pkg::t_pos  i_pos,
    input  wire logic [23:0]     i_background,
    output logic                 o_valid,
    output trtd_pkg::t_out_res   o_res
);
    import trtd_pkg::*;

    logic        r_s2_valid;
    logic        r_s2_opaque;
    logic [15:0] r_s2_num [3];
    t_pos        r_s2_pos;

    logic [15:0] n_s2_num [3];
    logic [7:0]  alpha;
    logic [7:0]  n_chan [3];

    logic        r_s3_valid;
    t_out_res    r_s3_res;
    t_out_res    n_s3_res;

    // channel 0 red, 1 green, 2 blue
    always_comb begin
        logic [3:0] c4;
        logic [7:0] c8;
        logic [7:0] bg;
        logic [15:0] p_fg;
        logic [15:0] p_bg;
        alpha = widen3(i_word[14:12]);
        for (int i = 0; i < 3; i++) begin
            c4   = i_word[8-4*i +: 4];
            c8   = {c4, c4};
            bg   = i_background[8*i +: 8];
            p_fg = {8'd0, c8} * {8'd0, alpha};
            p_bg = {8'd0, bg} * {8'd0, 8'd255 - alpha};
            if (i_word[15]) begin
                n_s2_num[i] = {8'd0, widen5(i_word[10-5*i +: 5])};
            end else begin
                n_s2_num[i] = p_fg + p_bg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_opaque <= i_word[15];
            r_s2_pos    <= i_pos;
            for (int i = 0; i < 3; i++) begin
                r_s2_num[i] <= n_s2_num[i];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_chan[i] = r_s2_opaque ? r_s2_num[i][7:0] : div255(r_s2_num[i]);
        end
        n_s3_res.pixel_x    = r_s2_pos.pixel_x;
        n_s3_res.pixel_y    = r_s2_pos.pixel_y;
        n_s3_res.red        = n_chan[0];
        n_s3_res.green      = n_chan[1];
        n_s3_res.blue       = n_chan[2];
        n_s3_res.last_pixel = r_s2_pos.last_pixel;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3_res <= n_s3_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (i_en) begin
            r_s2_valid <= i_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    assign o_valid = r_s3_valid;
    assign o_res   = r_s3_res;

endmodule

`default_nettype wire

// ----- rtl/core/tiled_rgb5a3_texture_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// tiled_rgb5a3_texture_decoder_unit
// tiled rgb5a3 and palette index texture decoder, top level
// ----------------------------------------------------------------------------
// Takes one request per cycle (texel or palette write) while the output is not
// stalled and returns one raster pixel per texel request, with no gaps at
// full rate. The three register stages are the palette read, the channel
// products and the divide by 255 into the result register; the whole pipe
// holds while a result waits under stall. A palette write returns nothing
// and is visible to the very next texel request. Geometry writes restart
// the tile walk at the image origin.
`default_nettype none

`include "tiled_rgb5a3_texture_decoder_unit_assert.svh"

module tiled_rgb5a3_texture_decoder_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire trtd_pkg::t_in_req                  i_in_req,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output trtd_pkg::t_out_res                      o_out_res,
    input  wire logic                               i_cfg_we,
    input  wire logic [trtd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [trtd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import trtd_pkg::*;

    logic        r_indexed;
    logic [7:0]  r_image_width;
    logic [6:0]  r_image_height;
    logic [23:0] r_background;

    logic        en;
    logic        in_accept;
    logic        geom_clear;
    t_pos        pos;
    t_pos        s1_pos;
    logic        s1_valid;
    logic [15:0] s1_word;

    assign en         = !o_out_valid || !i_out_stall;
    assign o_in_stall = !en;
    assign in_accept  = i_in_valid && en;
    assign geom_clear = i_cfg_we && ((i_cfg_index == REG_INDEXED_MODE)
                                  || (i_cfg_index == REG_IMAGE_WIDTH)
                                  || (i_cfg_index == REG_IMAGE_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_indexed      <= 1'b0;
            r_image_width  <= 8'd96;
            r_image_height <= 7'd32;
            r_background   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_INDEXED_MODE: r_indexed      <= i_cfg_data[0];
                REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[7:0];
                REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[6:0];
                REG_BACKGROUND:   r_background   <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    trtd_position u_position (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_clear        (geom_clear),
        .i_step         (in_accept && (i_in_req.opcode == OP_TEXEL)),
        .i_indexed      (r_indexed),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .o_pos          (pos)
    );

    trtd_palette u_palette (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_accept  (in_accept),
        .i_req     (i_in_req),
        .i_pos     (pos),
        .i_indexed (r_indexed),
        .o_valid   (s1_valid),
        .o_word    (s1_word),
        .o_pos     (s1_pos)
    );

    trtd_color u_color (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (s1_valid),
        .i_word       (s1_word),
        .i_pos        (s1_pos),
        .i_background (r_background),
        .o_valid      (o_out_valid),
        .o_res        (o_out_res)
    );

    // a palette write leaves a bubble behind it
    `TRTD_ASSERT(a_palette_write_no_pixel, in_accept && (i_in_req.opcode == OP_PALETTE_WRITE) |=> !s1_valid)

    // a geometry write restarts the walk at the origin
    `TRTD_ASSERT(a_geometry_restart, geom_clear |=> (pos.pixel_x == 7'd0) && (pos.pixel_y == 6'd0))

    // the last pixel of an image sits on the far edge of a tile row
    `TRTD_ASSERT(a_last_pixel_corner, pos.last_pixel |-> (pos.pixel_x[2:0] == 3'd7) && (pos.pixel_y[1:0] == 2'd3))

endmodule

`default_nettype wire
